// ----- rtl/core/bsc_pkg.sv -----
// Package for the binding slot cache: function codes, widths, controller
// state type and the command/status structs between controller and datapath.
// No dependencies.
package bsc_pkg;

   localparam int DEFAULT_SLOTS = 32;
   localparam int FUNC_W = 2;
   localparam int ID_W = 32;
   localparam int TARGET_W = 16;
   localparam int IDX_W = 5;
   localparam int CFG_W = 6;

   localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 6'd31;

   localparam logic [FUNC_W-1:0] FUNC_BIND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_UNBIND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UNBIND_ALL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic match_en;
      logic apply;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_bind;
      logic out_blocked;
   } ctl_status_type;

endpackage

// ----- rtl/core/bsc_ctrl.sv -----
// Controller for the binding slot cache: capture, compare, apply sequence.
// Depends on bsc_pkg; drives the datapath through ctl_cmd_type.
module bsc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bsc_pkg::ctl_status_type status,
   output bsc_pkg::ctl_cmd_type    cmd
);

   bsc_pkg::state_type state_ff;
   bsc_pkg::state_type state_in;
   logic               apply_go;

   assign apply_go = !(status.is_bind && status.out_blocked);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsc_pkg::ST_IDLE: begin
            if (req_valid) state_in = bsc_pkg::ST_MATCH;
         end
         bsc_pkg::ST_MATCH: begin
            state_in = bsc_pkg::ST_APPLY;
         end
         bsc_pkg::ST_APPLY: begin
            if (apply_go) state_in = bsc_pkg::ST_IDLE;
         end
         default: begin
            state_in = bsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.load     = 1'b0;
      cmd.match_en = 1'b0;
      cmd.apply    = 1'b0;
      case (state_ff)
         bsc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         bsc_pkg::ST_MATCH: begin
            cmd.match_en = 1'b1;
         end
         bsc_pkg::ST_APPLY: begin
            cmd.apply = apply_go;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/bsc_datapath.sv -----
// Datapath for the binding slot cache: slot tags, valid bits, round-robin
// pointer, slot count register and the result register. Depends on bsc_pkg.
module bsc_datapath #(
   parameter int SLOTS = bsc_pkg::DEFAULT_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bsc_pkg::ctl_cmd_type          cmd,
   output bsc_pkg::ctl_status_type       status,
   input  logic [bsc_pkg::FUNC_W-1:0]    req_func,
   input  logic [bsc_pkg::ID_W-1:0]      req_object_id,
   input  logic [bsc_pkg::TARGET_W-1:0]  req_target_code,
   input  logic                          csr_write,
   input  logic [bsc_pkg::CFG_W-1:0]     csr_slot_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsc_pkg::IDX_W-1:0]     rsp_slot_index,
   output logic                          rsp_newly_bound,
   output logic [bsc_pkg::TARGET_W-1:0]  rsp_target_out
);

   localparam int PW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int CMPW = (CW > bsc_pkg::CFG_W) ? CW : bsc_pkg::CFG_W;

   logic [bsc_pkg::FUNC_W-1:0]   func_ff;
   logic [bsc_pkg::ID_W-1:0]     id_ff;
   logic [bsc_pkg::TARGET_W-1:0] target_ff;
   logic [SLOTS-1:0]             match_ff;
   logic [SLOTS-1:0]             match_in;
   logic [SLOTS-1:0]             slot_valid_ff;
   logic [SLOTS-1:0]             slot_valid_in;
   logic [bsc_pkg::ID_W-1:0]     slot_object_ff [SLOTS];
   logic [PW-1:0]                next_slot_ff;
   logic [PW-1:0]                next_slot_in;
   logic [bsc_pkg::CFG_W-1:0]    slot_count_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [bsc_pkg::IDX_W-1:0]    rsp_slot_ff;
   logic [bsc_pkg::IDX_W-1:0]    rsp_slot_in;
   logic                         rsp_new_ff;
   logic                         rsp_new_in;
   logic [bsc_pkg::TARGET_W-1:0] rsp_target_ff;
   logic [bsc_pkg::TARGET_W-1:0] rsp_target_in;

   logic [CMPW-1:0]              count_ext;
   logic [CMPW-1:0]              active;
   logic [PW-1:0]                victim;
   logic [CMPW-1:0]              victim_inc;
   logic [PW-1:0]                ptr_adv;
   logic [PW-1:0]                hit_idx;
   logic                         hit;
   logic [PW-1:0]                sel_slot;
   logic [PW+bsc_pkg::IDX_W-1:0] sel_wide;
   logic                         do_bind;
   logic                         do_alloc;

   // active slot count: zero acts as one, saturates at SLOTS
   always_comb begin
      count_ext = CMPW'(slot_count_ff);
      if (count_ext == '0) begin
         active = CMPW'(1);
      end else if (count_ext > CMPW'(SLOTS)) begin
         active = CMPW'(SLOTS);
      end else begin
         active = count_ext;
      end
   end

   always_comb begin
      victim     = (CMPW'(next_slot_ff) >= active) ? '0 : next_slot_ff;
      victim_inc = CMPW'(victim) + CMPW'(1);
      ptr_adv    = (victim_inc == active) ? '0 : victim_inc[PW-1:0];
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = slot_valid_ff[i] && (slot_object_ff[i] == id_ff);
      end
   end

   // lowest matching slot wins
   always_comb begin
      hit_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = PW'(i);
      end
   end

   assign hit      = |match_ff;
   assign do_bind  = cmd.apply && (func_ff == bsc_pkg::FUNC_BIND);
   assign do_alloc = do_bind && !hit;
   assign sel_slot = hit ? hit_idx : victim;
   assign sel_wide = (PW + bsc_pkg::IDX_W)'(sel_slot);

   always_comb begin
      slot_valid_in = slot_valid_ff;
      next_slot_in  = next_slot_ff;
      if (cmd.apply) begin
         case (func_ff)
            bsc_pkg::FUNC_BIND: begin
               if (!hit) begin
                  slot_valid_in[victim] = 1'b1;
                  next_slot_in          = ptr_adv;
               end
            end
            bsc_pkg::FUNC_UNBIND: begin
               slot_valid_in = slot_valid_ff & ~match_ff;
            end
            bsc_pkg::FUNC_UNBIND_ALL: begin
               slot_valid_in = '0;
               next_slot_in  = '0;
            end
            default: begin
               slot_valid_in = slot_valid_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_target_in = rsp_target_ff;
      if (do_bind) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = sel_wide[bsc_pkg::IDX_W-1:0];
         rsp_new_in    = !hit;
         rsp_target_in = hit ? '0 : target_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         next_slot_ff  <= '0;
         slot_count_ff <= bsc_pkg::SLOT_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         next_slot_ff  <= next_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) slot_count_ff <= csr_slot_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         id_ff     <= req_object_id;
         target_ff <= req_target_code;
      end
      if (cmd.match_en) match_ff <= match_in;
      if (do_alloc) slot_object_ff[victim] <= id_ff;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_target_ff <= rsp_target_in;
   end

   assign status.is_bind     = (func_ff == bsc_pkg::FUNC_BIND);
   assign status.out_blocked = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_newly_bound = rsp_new_ff;
   assign rsp_target_out  = rsp_target_ff;

`ifndef SYNTH
   // tags of valid slots stay unique, so a lookup matches one slot at most
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> $onehot0(match_ff))
      else $error("more than one slot matched");

   a_unbind_all_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && func_ff == bsc_pkg::FUNC_UNBIND_ALL)
      |=> (slot_valid_ff == '0 && next_slot_ff == '0))
      else $error("unbind-all left state behind");

   a_bind_gives_word: assert property (@(posedge clock) disable iff (reset)
      do_bind |=> rsp_valid_ff)
      else $error("bind produced no result word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !do_bind)
      else $error("result register overwritten while held");
`endif

endmodule

// ----- rtl/core/binding_slot_cache_round_robin.sv -----
// Binding slot cache: maps 32-bit object identifiers onto SLOTS binding
// slots, fully associative, round-robin replacement. A request passes the
// states in order: idle captures the word, match compares the identifier
// against every slot tag, apply resolves the lowest match and updates the
// tags, valid bits and pointer. A bind waits in apply while the previous
// result word is still held on rsp_. Bind returns one result word; unbind
// and unbind-all return none. csr_ writes set the active slot count and
// are always accepted; write them only while no request is in flight.
module binding_slot_cache_round_robin #(
   parameter int SLOTS = bsc_pkg::DEFAULT_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bsc_pkg::FUNC_W-1:0]    req_func,
   input  logic [bsc_pkg::ID_W-1:0]      req_object_id,
   input  logic [bsc_pkg::TARGET_W-1:0]  req_target_code,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsc_pkg::IDX_W-1:0]     rsp_slot_index,
   output logic                          rsp_newly_bound,
   output logic [bsc_pkg::TARGET_W-1:0]  rsp_target_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsc_pkg::CFG_W-1:0]     csr_slot_count
);

   bsc_pkg::ctl_cmd_type    cmd;
   bsc_pkg::ctl_status_type status;

   assign csr_ready = 1'b1;

   bsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsc_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_object_id   (req_object_id),
      .req_target_code (req_target_code),
      .csr_write       (csr_valid && csr_ready),
      .csr_slot_count  (csr_slot_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_newly_bound (rsp_newly_bound),
      .rsp_target_out  (rsp_target_out)
   );

endmodule
